// File: sv/sbfr_pkg.sv
package sbfr_pkg;

    // Reset value of the start byte register (ASCII 'w').
    localparam logic [7:0] START_BYTE_RESET = 8'h77;

    // Function code of a heartbeat request.
    localparam logic [7:0] FUNC_HEARTBEAT = 8'h43;

    // Register map: index of each configuration register.
    localparam int unsigned REG_START_BYTE = 0;

    // Receive phase, one-hot.
    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    // Position of the next header byte within the header.
    localparam logic [2:0] POS_NONE   = 3'd0;
    localparam logic [2:0] POS_CHECK  = 3'd1;
    localparam logic [2:0] POS_FUNC   = 3'd2;
    localparam logic [2:0] POS_LEN    = 3'd3;
    localparam logic [2:0] POS_ID_LO  = 3'd4;
    localparam logic [2:0] POS_ID_HI  = 3'd5;

    // One result item.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        data_valid;
        logic        frame_end;
        logic        frame_ok;
        logic [7:0]  func_code;
        logic [15:0] device_id;
        logic [7:0]  payload_len;
        logic        heartbeat_reply;
    } t_result;

endpackage

// File: sv/sbfr_parser.sv
module sbfr_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_start_byte,
    input  logic             i_take,
    input  logic [7:0]       i_rx_byte,
    output logic             o_res_valid,
    output sbfr_pkg::t_result o_res
);

    sbfr_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_func, n_func;
    logic [7:0]  r_len, n_len;
    logic [15:0] r_id, n_id;
    logic [7:0]  r_check, n_check;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_remaining, n_remaining;
    logic        emit_data;
    logic        emit_end;
    logic        ok;

    // Next state and result for the byte in this transfer.
    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_func      = r_func;
        n_len       = r_len;
        n_id        = r_id;
        n_check     = r_check;
        n_sum       = r_sum;
        n_remaining = r_remaining;
        o_res_valid = 1'b0;
        emit_data   = 1'b0;
        emit_end    = 1'b0;
        if (i_take) begin
            unique case (r_phase)
                sbfr_pkg::PH_HEADER: begin
                    unique case (r_pos)
                        sbfr_pkg::POS_CHECK: begin
                            n_check = i_rx_byte;
                            n_pos   = sbfr_pkg::POS_FUNC;
                        end
                        sbfr_pkg::POS_FUNC: begin
                            n_func = i_rx_byte;
                            n_sum  = i_rx_byte;
                            n_pos  = sbfr_pkg::POS_LEN;
                        end
                        sbfr_pkg::POS_LEN: begin
                            n_len = i_rx_byte;
                            n_sum = r_sum + i_rx_byte;
                            n_pos = sbfr_pkg::POS_ID_LO;
                        end
                        sbfr_pkg::POS_ID_LO: begin
                            n_id  = {8'h00, i_rx_byte};
                            n_sum = r_sum + i_rx_byte;
                            n_pos = sbfr_pkg::POS_ID_HI;
                        end
                        sbfr_pkg::POS_ID_HI: begin
                            n_id  = {i_rx_byte, r_id[7:0]};
                            n_sum = r_sum + i_rx_byte;
                            n_pos = sbfr_pkg::POS_NONE;
                            if (r_len == 8'h00) begin
                                // Empty payload: the header closes the frame.
                                n_phase     = sbfr_pkg::PH_HUNT;
                                o_res_valid = 1'b1;
                                emit_end    = 1'b1;
                            end else begin
                                n_remaining = r_len;
                                n_phase     = sbfr_pkg::PH_PAYLOAD;
                            end
                        end
                        default: begin
                            n_pos   = sbfr_pkg::POS_NONE;
                            n_phase = sbfr_pkg::PH_HUNT;
                        end
                    endcase
                end
                sbfr_pkg::PH_PAYLOAD: begin
                    n_sum       = r_sum + i_rx_byte;
                    n_remaining = r_remaining - 8'd1;
                    emit_data   = 1'b1;
                    emit_end    = (n_remaining == 8'h00);
                    o_res_valid = 1'b1;
                    if (emit_end) begin
                        n_phase = sbfr_pkg::PH_HUNT;
                    end
                end
                default: begin
                    // Hunting: drop everything but the start byte.
                    n_phase = sbfr_pkg::PH_HUNT;
                    if (i_rx_byte == i_start_byte) begin
                        n_phase = sbfr_pkg::PH_HEADER;
                        n_pos   = sbfr_pkg::POS_CHECK;
                        n_sum   = 8'h00;
                    end
                end
            endcase
        end
    end

    // Result fields are built from the updated header and sum.
    assign ok = emit_end && (n_sum == r_check);

    always_comb begin
        o_res.data_byte       = emit_data ? i_rx_byte : 8'h00;
        o_res.data_valid      = emit_data;
        o_res.frame_end       = emit_end;
        o_res.frame_ok        = ok;
        o_res.func_code       = n_func;
        o_res.device_id       = n_id;
        o_res.payload_len     = n_len;
        o_res.heartbeat_reply = ok && (n_func == sbfr_pkg::FUNC_HEARTBEAT);
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= sbfr_pkg::PH_HUNT;
            r_pos       <= sbfr_pkg::POS_NONE;
            r_func      <= 8'h00;
            r_len       <= 8'h00;
            r_id        <= 16'h0000;
            r_check     <= 8'h00;
            r_sum       <= 8'h00;
            r_remaining <= 8'h00;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_func      <= n_func;
            r_len       <= n_len;
            r_id        <= n_id;
            r_check     <= n_check;
            r_sum       <= n_sum;
            r_remaining <= n_remaining;
        end
    end

endmodule

// File: sv/sbfr_out_reg.sv
module sbfr_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic              i_load,
    input  sbfr_pkg::t_result i_res,
    input  logic              i_out_ready,
    output logic              o_can_take,
    output logic              o_valid,
    output sbfr_pkg::t_result o_res
);

    logic              r_valid;
    sbfr_pkg::t_result r_res;

    // A new byte may enter when the held result is empty or leaves now.
    assign o_can_take = !r_valid || i_out_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    // Valid flag of the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take && i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_take && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// File: sv/start_byte_frame_receiver_core.sv
// Byte-serial receiver for start-byte framed packets. It accepts one received byte per
// clock cycle with no bubbles while i_ready is high: each byte goes through a small state
// update into a single result register, and the next byte is taken in the same cycle that
// the held result leaves, so throughput is one byte per cycle, and the result is registered
// in the cycle after its input transfer. Bytes are dropped until the start byte (register
// at address 0, reset 0x77) is seen; the six header bytes give no result except when the
// payload length is zero, in which case the last id byte gives one frame-end result. Each
// payload byte is passed on as it arrives; the final one carries frame_end and frame_ok,
// and a consumer must discard the frame's bytes when frame_ok is 0. heartbeat_reply marks
// the end of a good frame with function 0x43.
module start_byte_frame_receiver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Received bytes
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    // Results
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_data_byte,
    output logic        o_data_valid,
    output logic        o_frame_end,
    output logic        o_frame_ok,
    output logic [7:0]  o_func_code,
    output logic [15:0] o_device_id,
    output logic [7:0]  o_payload_len,
    output logic        o_heartbeat_reply
);

    logic [7:0]        r_start_byte;
    logic              reg_sel;
    logic              take;
    logic              can_take;
    logic              res_valid;
    sbfr_pkg::t_result res;
    sbfr_pkg::t_result out_res;

    // Register decode: word index from the byte address.
    assign reg_sel = (paddr[2] == sbfr_pkg::REG_START_BYTE[0]);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {24'h000000, r_start_byte} : 32'h00000000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= sbfr_pkg::START_BYTE_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_start_byte <= pwdata[7:0];
        end
    end

    // Input transfer.
    assign o_rx_ready = can_take;
    assign take       = i_rx_valid && can_take;

    sbfr_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start_byte (r_start_byte),
        .i_take       (take),
        .i_rx_byte    (i_rx_byte),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    sbfr_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_load      (res_valid),
        .i_res       (res),
        .i_out_ready (i_ready),
        .o_can_take  (can_take),
        .o_valid     (o_valid),
        .o_res       (out_res)
    );

    // Result fields.
    assign o_data_byte       = out_res.data_byte;
    assign o_data_valid      = out_res.data_valid;
    assign o_frame_end       = out_res.frame_end;
    assign o_frame_ok        = out_res.frame_ok;
    assign o_func_code       = out_res.func_code;
    assign o_device_id       = out_res.device_id;
    assign o_payload_len     = out_res.payload_len;
    assign o_heartbeat_reply = out_res.heartbeat_reply;

endmodule

// File: sv/sbfr_checker.sv
module sbfr_port_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        i_rx_valid,
    input  logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [7:0]  o_data_byte,
    input  logic        o_data_valid,
    input  logic        o_frame_end,
    input  logic        o_frame_ok,
    input  logic [7:0]  o_func_code,
    input  logic [15:0] o_device_id,
    input  logic [7:0]  o_payload_len,
    input  logic        o_heartbeat_reply
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped before transfer");

    // A stalled result keeps its payload byte and frame_end flag.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_data_byte) && $stable(o_frame_end))
        else $error("stalled result changed");

    // A heartbeat reply only closes a good heartbeat frame.
    a_heartbeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_heartbeat_reply |->
            o_frame_end && o_frame_ok && (o_func_code == sbfr_pkg::FUNC_HEARTBEAT))
        else $error("heartbeat reply outside a good heartbeat frame end");

    // Results inside a frame are payload bytes and never report a check.
    a_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_frame_end |-> o_data_valid && !o_frame_ok)
        else $error("mid-frame result without payload or with frame_ok");

    // A result without payload can only be the end of an empty frame.
    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data_valid |->
            o_frame_end && (o_payload_len == 8'h00) && (o_data_byte == 8'h00))
        else $error("result without payload outside an empty frame");

endmodule

bind start_byte_frame_receiver_core sbfr_port_checker u_sbfr_port_checker (.*);
